// ===== rtl/core/fstrm_pkg.sv =====
// Package for the fan switch / tach RPM meter: states, command and status
// structs, field widths and arithmetic constants. No dependencies.
package fstrm_pkg;

  localparam int unsigned NOW_W     = 32;
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned IVL_W     = 16;
  localparam int unsigned TALLY_W   = 32;
  localparam int unsigned NUM_W     = 48;  // tally * 60000 never wraps
  localparam int unsigned DIV_STEPS = 16;  // one quotient bit per step
  localparam int unsigned CNT_W     = 4;

  localparam logic [15:0]      RPM_PER_MIN = 16'd60000;
  localparam logic [RPM_W-1:0] RPM_MAX     = 16'hFFFF;
  localparam logic [TALLY_W-1:0] TALLY_MAX = 32'hFFFF_FFFF;

  // Item opcodes
  localparam logic OP_TACH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_AUTO_MODE = 2'd0;
  localparam logic [1:0] REG_MANUAL_ON = 2'd1;
  localparam logic [1:0] REG_INTERVAL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_CHK,
    S_DIV,
    S_PUB
  } fstrm_state_t;

  typedef struct packed {
    logic latch;     // capture accepted input word
    logic eval;      // fan switch logic, tally count, interval test
    logic mul;       // form numerator and denominator
    logic chk;       // saturation test, divider set-up
    logic div_step;  // one restoring division step
    logic pub;       // load output register
  } fstrm_cmd_t;

  typedef struct packed {
    logic meas;      // this tick starts a measurement
    logic sat;       // quotient would exceed RPM_MAX
    logic div_last;  // final division step
  } fstrm_sts_t;

endpackage

// ===== rtl/core/fstrm_ctrl.sv =====
// Controller FSM for the fan switch / tach RPM meter.
// Depends on fstrm_pkg.
module fstrm_ctrl import fstrm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fstrm_sts_t sts,
  output fstrm_cmd_t cmd
);

  fstrm_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = sts.meas ? S_MUL : S_PUB;
      S_MUL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = sts.sat ? S_PUB : S_DIV;
      S_DIV:  if (sts.div_last) state_nxt = S_PUB;
      S_PUB:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_EVAL: cmd.eval     = 1'b1;
      S_MUL:  cmd.mul      = 1'b1;
      S_CHK:  cmd.chk      = 1'b1;
      S_DIV:  cmd.div_step = 1'b1;
      S_PUB:  cmd.pub      = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.pub) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/fstrm_dp.sv =====
// Datapath for the fan switch / tach RPM meter: state registers, multiplier,
// restoring divider and output register. Depends on fstrm_pkg.
module fstrm_dp import fstrm_pkg::*; #(
  parameter int unsigned PULSES_PER_REV = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fstrm_cmd_t       cmd,
  output fstrm_sts_t       sts,
  input  logic             in_op,
  input  logic [NOW_W-1:0] in_now_ms,
  input  logic             in_auto_demand,
  input  logic             auto_mode,
  input  logic             manual_on,
  input  logic [IVL_W-1:0] interval_ms,
  output logic             out_fan_on,
  output logic [RPM_W-1:0] out_rpm,
  output logic             out_rpm_updated
);

  localparam int unsigned PPR_W = $clog2(PULSES_PER_REV + 1);
  localparam int unsigned DEN_W = NOW_W + PPR_W;
  localparam int unsigned CMP_W = DEN_W + RPM_W;

  // captured word
  logic             op_r;
  logic [NOW_W-1:0] now_r;
  logic             demand_r;

  // measurement state
  logic               fan_r;
  logic [RPM_W-1:0]   speed_r;
  logic [TALLY_W-1:0] tally_r;
  logic [NOW_W-1:0]   start_r;
  logic               meas_r;
  logic [NOW_W-1:0]   elapsed_r;

  // arithmetic
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [CMP_W-1:0] rem_r, rem_nxt;
  logic [CMP_W-1:0] dsh_r;
  logic [RPM_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic             want;
  logic [NOW_W-1:0] elapsed_c;
  logic [IVL_W-1:0] limit;
  logic             meas_c;
  logic             ge;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_op;
      now_r    <= in_now_ms;
      demand_r <= in_auto_demand;
    end
  end

  assign want      = auto_mode ? demand_r : manual_on;
  assign elapsed_c = now_r - start_r;
  assign limit     = (interval_ms == '0) ? IVL_W'(1) : interval_ms;
  assign meas_c    = (op_r == OP_TICK) && want &&
                     (elapsed_c >= {{(NOW_W-IVL_W){1'b0}}, limit});

  assign ge       = rem_r >= dsh_r;
  assign rem_nxt  = ge ? (rem_r - dsh_r) : rem_r;
  assign quot_nxt = {quot_r[RPM_W-2:0], ge};

  assign sts.meas     = meas_c;
  assign sts.sat      = {{(CMP_W-NUM_W){1'b0}}, num_r} >= {den_r, {RPM_W{1'b0}}};
  assign sts.div_last = (cnt_r == '0);

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_r   <= 1'b0;
      speed_r <= '0;
      tally_r <= '0;
      start_r <= '0;
    end else begin
      if (cmd.eval) begin
        if (op_r == OP_TACH) begin
          if (tally_r != TALLY_MAX) tally_r <= tally_r + TALLY_W'(1);
        end else begin
          fan_r <= want;
          if (fan_r && !want) begin
            speed_r <= '0;
            tally_r <= '0;
            start_r <= now_r;
          end
        end
      end
      if (cmd.mul) begin
        tally_r <= '0;
        start_r <= now_r;
      end
      if (cmd.chk && sts.sat) speed_r <= RPM_MAX;
      if (cmd.div_step && sts.div_last) speed_r <= quot_nxt;
    end
  end

  // divider and operand registers
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      meas_r    <= meas_c;
      elapsed_r <= elapsed_c;
    end
    if (cmd.mul) begin
      num_r <= NUM_W'(tally_r) * NUM_W'(RPM_PER_MIN);
      den_r <= DEN_W'(elapsed_r) * DEN_W'(PULSES_PER_REV);
    end
    if (cmd.chk) begin
      rem_r  <= {{(CMP_W-NUM_W){1'b0}}, num_r};
      dsh_r  <= {1'b0, den_r, {(RPM_W-1){1'b0}}};
      quot_r <= '0;
      cnt_r  <= CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
      dsh_r  <= dsh_r >> 1;
      cnt_r  <= cnt_r - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.pub) begin
      out_fan_on      <= fan_r;
      out_rpm         <= speed_r;
      out_rpm_updated <= meas_r;
    end
  end

endmodule

// ===== rtl/core/fan_switch_tach_rpm_meter_top.sv =====
// Fan switch and tachometer RPM meter, top level.
// Steps per accepted word: a tach edge or a tick without measurement goes
// evaluate, publish; a measuring tick goes evaluate, multiply, check, then
// publish if the RPM saturates, else 16 restoring-divider steps, publish.
// One word at a time; publish waits while out_valid is held by out_ready low.
// Reset (rst_n, synchronous): fan off, RPM, pulse count and interval start
// zero; auto_mode 0, manual_on 0, publish interval 1000 ms.
module fan_switch_tach_rpm_meter_top import fstrm_pkg::*; #(
  parameter int unsigned PULSES_PER_REV = 2  // 1 to 8
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [1:0]       cfg_idx,
  input  logic [IVL_W-1:0] cfg_wdata,
  // input words
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [NOW_W-1:0] in_now_ms,
  input  logic             in_auto_demand,
  // result words
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_fan_on,
  output logic [RPM_W-1:0] out_rpm,
  output logic             out_rpm_updated
);

  // Configuration registers; writes to an unused index are dropped.
  logic             auto_mode_r;
  logic             manual_on_r;
  logic [IVL_W-1:0] interval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r <= 1'b0;
      manual_on_r <= 1'b0;
      interval_r  <= IVL_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_AUTO_MODE: auto_mode_r <= cfg_wdata[0];
        REG_MANUAL_ON: manual_on_r <= cfg_wdata[0];
        REG_INTERVAL:  interval_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fstrm_cmd_t cmd;
  fstrm_sts_t sts;

  // Sequencer: evaluate, multiply, saturation check, divide, publish.
  fstrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Fan/tally state, 32x16 multiplier, bit-serial divider, output register.
  fstrm_dp #(
    .PULSES_PER_REV (PULSES_PER_REV)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_now_ms       (in_now_ms),
    .in_auto_demand  (in_auto_demand),
    .auto_mode       (auto_mode_r),
    .manual_on       (manual_on_r),
    .interval_ms     (interval_r),
    .out_fan_on      (out_fan_on),
    .out_rpm         (out_rpm),
    .out_rpm_updated (out_rpm_updated)
  );

endmodule
